>>> rtl/core/wprq_pkg.sv
// Package for the web palette run-length quantizer.
// Holds widths, register indexes, the transparent code and the result word type.
// No dependencies.
`default_nettype none

package wprq_pkg;

    localparam int LENGTH_BITS    = 20;
    localparam int WORD_BITS      = 32;
    localparam int CODE_BITS      = WORD_BITS - LENGTH_BITS;
    localparam int RUN_LEN_BITS   = 17;
    localparam int COUNT_BITS     = 16;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [CODE_BITS-1:0] CODE_CLEAR = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [WORD_BITS-1:0] run_word;
        logic                 last_of_row;
        logic                 last_of_page;
        logic                 fg_nonblack;
        logic                 bg_differs;
        logic [7:0]           ref_red;
        logic [7:0]           ref_green;
        logic [7:0]           ref_blue;
    } t_result;

    // second implies first
    typedef struct packed {
        logic first;
        logic second;
    } t_queue_push;

    typedef struct packed {
        logic valid;
        logic room;
    } t_queue_status;

endpackage

`default_nettype wire

>>> rtl/core/wprq_pix_if.sv
// Input channel: one foreground/background pixel pair per word.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface wprq_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;

    modport source (output valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
                    input ready);
    modport sink (input valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/wprq_run_if.sv
// Output channel: one run word with row/page marks, page flags and reference colour.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface wprq_run_if;
    logic        valid;
    logic        ready;
    logic [31:0] run_word;
    logic        last_of_row;
    logic        last_of_page;
    logic        fg_nonblack;
    logic        bg_differs;
    logic [7:0]  ref_red;
    logic [7:0]  ref_green;
    logic [7:0]  ref_blue;

    modport source (output valid, run_word, last_of_row, last_of_page, fg_nonblack,
                    bg_differs, ref_red, ref_green, ref_blue, input ready);
    modport sink (input valid, run_word, last_of_row, last_of_page, fg_nonblack,
                  bg_differs, ref_red, ref_green, ref_blue, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wprq_out_queue.sv
// Four-entry result queue that takes up to two words per cycle and gives one.
// Depends on wprq_pkg.
`default_nettype none

module wprq_out_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wprq_pkg::t_queue_push  i_push,
    input  wprq_pkg::t_result      i_first,
    input  wprq_pkg::t_result      i_second,
    input  logic                   i_pop,
    output wprq_pkg::t_result      o_head,
    output wprq_pkg::t_queue_status o_status
);
    import wprq_pkg::*;

    t_result                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count,  n_count;
    logic [QUEUE_PTR_BITS-1:0] w_wr_next;
    logic [QUEUE_CNT_BITS-1:0] w_push_n;
    logic                      w_pop;

    assign w_pop     = i_pop && (r_count != '0);
    assign w_push_n  = QUEUE_CNT_BITS'(i_push.first) + QUEUE_CNT_BITS'(i_push.second);
    assign w_wr_next = r_wr_ptr + QUEUE_PTR_BITS'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + w_push_n[QUEUE_PTR_BITS-1:0];
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_BITS'(w_pop);
        n_count  = r_count + w_push_n - QUEUE_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_first;
        end
        if (i_push.second) begin
            r_mem[w_wr_next] <= i_second;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    // keep room for the two words a single pixel can close
    assign o_status.room  = (r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

endmodule

`default_nettype wire

>>> rtl/core/web_palette_rle_quantizer_top.sv
// Top level of the web palette run-length quantizer.
// Depends on wprq_pkg, wprq_pix_if, wprq_run_if and wprq_out_queue.
//
//  Channel  Dir  Handshake       Word
//  i_pix    in   valid/ready     fg and bg RGB pixel, raster order
//  o_run    out  valid/ready     run word, row/page marks, flags, reference colour
//  i_cfg    in   write enable    image_width (index 0), image_height (index 1)
//
// One pixel is taken per cycle while i_pix.ready is high; it is quantized and
// its run closed in the cycle it is accepted; its words are queued for o_run.
// A pixel that closes two runs puts two words in the four-entry result queue, so
// i_pix.ready drops while fewer than two entries are free.
// Reset is synchronous and active low: empty queue, counters at zero, size 1 x 1.
`default_nettype none

module web_palette_rle_quantizer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wprq_pix_if.sink                           i_pix,
    wprq_run_if.source                         o_run,
    input  logic                               i_cfg_we,
    input  logic [wprq_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wprq_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import wprq_pkg::*;

    function automatic logic [2:0] quant(input logic [7:0] c);
        // (c + 1) / 43 as a count of thresholds
        quant = 3'(c >= 8'd42) + 3'(c >= 8'd85) + 3'(c >= 8'd128) +
                3'(c >= 8'd171) + 3'(c >= 8'd214);
    endfunction

    function automatic logic [CODE_BITS-1:0] palette_code(input logic [7:0] r,
                                                          input logic [7:0] g,
                                                          input logic [7:0] b);
        logic [7:0] sum;
        sum = 8'(quant(b)) + 8'(quant(g)) * 8'd6 + 8'(quant(r)) * 8'd36;
        palette_code = CODE_BITS'(sum);
    endfunction

    logic [COUNT_BITS-1:0]   r_width, r_height;
    logic [COUNT_BITS-1:0]   r_col, n_col;
    logic [COUNT_BITS-1:0]   r_row, n_row;
    logic [CODE_BITS-1:0]    r_cur_code, n_cur_code;
    logic [RUN_LEN_BITS-1:0] r_cur_len, n_cur_len;
    logic [23:0]             r_ref, n_ref;
    logic                    r_fg_seen, n_fg_seen;
    logic                    r_bg_var, n_bg_var;

    logic                    w_accept;
    logic                    w_page_start;
    logic [23:0]             w_fg_pix, w_bg_pix;
    logic                    w_opaque;
    logic [CODE_BITS-1:0]    w_code;
    logic                    w_continue, w_break;
    logic [RUN_LEN_BITS-1:0] w_len;
    logic                    w_row_end, w_page_end;

    t_result                 w_closed, w_final;
    t_queue_push             w_push;
    t_result                 w_head;
    t_queue_status           w_status;

    assign w_accept = i_pix.valid && i_pix.ready;
    assign w_fg_pix = {i_pix.fg_red, i_pix.fg_green, i_pix.fg_blue};
    assign w_bg_pix = {i_pix.bg_red, i_pix.bg_green, i_pix.bg_blue};

    always_comb begin
        w_page_start = (r_col == '0) && (r_row == '0);
        // latch the reference and clear the flags at page start
        n_ref     = w_page_start ? w_bg_pix : r_ref;
        n_bg_var  = (!w_page_start && r_bg_var) || (w_bg_pix != n_ref);
        w_opaque  = (w_fg_pix != w_bg_pix);
        n_fg_seen = (!w_page_start && r_fg_seen) || (w_opaque && (w_fg_pix != '0));
        w_code    = w_opaque ? palette_code(i_pix.fg_red, i_pix.fg_green, i_pix.fg_blue)
                             : CODE_CLEAR;

        w_continue = (r_cur_len != '0) && (w_code == r_cur_code);
        w_break    = (r_cur_len != '0) && !w_continue;
        w_len      = w_continue ? r_cur_len + RUN_LEN_BITS'(1) : RUN_LEN_BITS'(1);

        w_row_end  = ({1'b0, r_col} + 17'd1) >= {1'b0, r_width};
        w_page_end = w_row_end && (({1'b0, r_row} + 17'd1) >= {1'b0, r_height});

        if (w_row_end) begin
            n_cur_code = CODE_CLEAR;
            n_cur_len  = '0;
            n_col      = '0;
            n_row      = w_page_end ? '0 : r_row + COUNT_BITS'(1);
        end else begin
            n_cur_code = w_code;
            n_cur_len  = w_len;
            n_col      = r_col + COUNT_BITS'(1);
            n_row      = r_row;
        end
    end

    always_comb begin
        w_closed.run_word     = {r_cur_code, LENGTH_BITS'(r_cur_len)};
        w_closed.last_of_row  = 1'b0;
        w_closed.last_of_page = 1'b0;
        w_closed.fg_nonblack  = n_fg_seen;
        w_closed.bg_differs   = n_bg_var;
        w_closed.ref_red      = n_ref[23:16];
        w_closed.ref_green    = n_ref[15:8];
        w_closed.ref_blue     = n_ref[7:0];

        w_final              = w_closed;
        w_final.run_word     = {w_code, LENGTH_BITS'(w_len)};
        w_final.last_of_row  = 1'b1;
        w_final.last_of_page = w_page_end;

        w_push.first  = w_accept && (w_break || w_row_end);
        w_push.second = w_accept && w_break && w_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= COUNT_BITS'(1);
            r_height   <= COUNT_BITS'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_cur_code <= CODE_CLEAR;
            r_cur_len  <= '0;
            r_ref      <= '0;
            r_fg_seen  <= 1'b0;
            r_bg_var   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_cur_code <= n_cur_code;
                r_cur_len  <= n_cur_len;
                r_ref      <= n_ref;
                r_fg_seen  <= n_fg_seen;
                r_bg_var   <= n_bg_var;
            end
        end
    end

    wprq_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_first  (w_break ? w_closed : w_final),
        .i_second (w_final),
        .i_pop    (o_run.ready),
        .o_head   (w_head),
        .o_status (w_status)
    );

    assign i_pix.ready        = w_status.room;
    assign o_run.valid        = w_status.valid;
    assign o_run.run_word     = w_head.run_word;
    assign o_run.last_of_row  = w_head.last_of_row;
    assign o_run.last_of_page = w_head.last_of_page;
    assign o_run.fg_nonblack  = w_head.fg_nonblack;
    assign o_run.bg_differs   = w_head.bg_differs;
    assign o_run.ref_red      = w_head.ref_red;
    assign o_run.ref_green    = w_head.ref_green;
    assign o_run.ref_blue     = w_head.ref_blue;

endmodule

`default_nettype wire

>>> rtl/core/wprq_checker.sv
// Port-level checks for the web palette run-length quantizer, bound to the top level.
// Depends on wprq_pkg and web_palette_rle_quantizer_top.
`default_nettype none

module wprq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [wprq_pkg::WORD_BITS-1:0] i_run_word,
    input logic                           i_last_of_row,
    input logic                           i_last_of_page
);
    import wprq_pkg::*;

    logic [CODE_BITS-1:0]   w_code;
    logic [LENGTH_BITS-1:0] w_len;

    assign w_code = i_run_word[WORD_BITS-1:LENGTH_BITS];
    assign w_len  = i_run_word[LENGTH_BITS-1:0];

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_page_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_of_page |-> i_last_of_row)
        else $error("page end without row end");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (w_len != '0))
        else $error("empty run emitted");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((w_code <= CODE_BITS'(215)) || (w_code == CODE_CLEAR)))
        else $error("color code outside palette");

endmodule

bind web_palette_rle_quantizer_top wprq_checker u_wprq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_run.valid),
    .i_out_ready    (o_run.ready),
    .i_run_word     (o_run.run_word),
    .i_last_of_row  (o_run.last_of_row),
    .i_last_of_page (o_run.last_of_page)
);

`default_nettype wire

>>> tb/sv/web_palette_rle_quantizer_top_test.sv
// Self-checking bench for web_palette_rle_quantizer_top: pixel pairs in, run words out.
// Depends on wprq_pkg, wprq_pix_if and wprq_run_if; predicts each run word in-bench and
// compares it field by field while both channels idle and stall, partly at random.

module web_palette_rle_quantizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wprq_pkg::*;

    typedef struct packed {
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
    } t_pixel;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    wprq_pix_if pix_ch ();
    wprq_run_if run_ch ();

    web_palette_rle_quantizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_run      (run_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // pixels waiting for the driver, run words waiting for the monitor
    t_pixel  pixel_queue[$];
    t_result runs_due[$];

    // encoder image: size registers and page/run state
    logic [COUNT_BITS-1:0]   width_reg;
    logic [COUNT_BITS-1:0]   height_reg;
    logic [COUNT_BITS-1:0]   col_count;
    logic [COUNT_BITS-1:0]   row_count;
    logic [CODE_BITS-1:0]    run_code;
    logic [RUN_LEN_BITS-1:0] run_len;
    logic [23:0]             ref_colour;
    logic                    fg_seen;
    logic                    bg_varies;

    int error_count;
    int pixels_queued;
    int pixels_taken;
    int runs_checked;
    int rows_closed;
    int pages_closed;
    int size_settings;
    int cycle_count;

    // random generator memory
    t_pixel      last_pixel;
    logic [23:0] page_bg;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.fg_red = '0;
        pix_ch.fg_green = '0;
        pix_ch.fg_blue = '0;
        pix_ch.bg_red = '0;
        pix_ch.bg_green = '0;
        pix_ch.bg_blue = '0;
        run_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic logic [2:0] web_level(input logic [7:0] c);
        return 3'((int'(c) + 1) / 43);
    endfunction

    function automatic t_result run_result(input logic [CODE_BITS-1:0] code,
                                           input logic [RUN_LEN_BITS-1:0] len,
                                           input logic row_end, input logic page_end);
        t_result r;
        r.run_word     = (WORD_BITS'(code) << LENGTH_BITS) | WORD_BITS'(len);
        r.last_of_row  = row_end;
        r.last_of_page = page_end;
        r.fg_nonblack  = fg_seen;
        r.bg_differs   = bg_varies;
        r.ref_red      = ref_colour[23:16];
        r.ref_green    = ref_colour[15:8];
        r.ref_blue     = ref_colour[7:0];
        return r;
    endfunction

    // quantize one accepted pixel and queue the run words it closes
    task automatic encode_pixel(input t_pixel p);
        logic [23:0]          fg_pix;
        logic [23:0]          bg_pix;
        logic [CODE_BITS-1:0] code;
        logic                 row_end;
        logic                 page_end;
        fg_pix = {p.fg_red, p.fg_green, p.fg_blue};
        bg_pix = {p.bg_red, p.bg_green, p.bg_blue};
        if (col_count == 0 && row_count == 0) begin
            ref_colour = bg_pix;
            fg_seen = 1'b0;
            bg_varies = 1'b0;
        end
        if (bg_pix != ref_colour)
            bg_varies = 1'b1;
        if (fg_pix != bg_pix) begin
            if (fg_pix != 0)
                fg_seen = 1'b1;
            code = CODE_BITS'(web_level(p.fg_blue))
                 + CODE_BITS'(6) * (CODE_BITS'(web_level(p.fg_green))
                 + CODE_BITS'(6) * CODE_BITS'(web_level(p.fg_red)));
        end else begin
            code = CODE_CLEAR;
        end
        if (run_len > 0 && code == run_code) begin
            run_len++;
        end else begin
            if (run_len > 0)
                runs_due.push_back(run_result(run_code, run_len, 1'b0, 1'b0));
            run_code = code;
            run_len = 1;
        end
        // a size register of zero behaves like one
        row_end = (int'(col_count) + 1) >= int'(width_reg);
        page_end = row_end && ((int'(row_count) + 1) >= int'(height_reg));
        if (row_end) begin
            runs_due.push_back(run_result(run_code, run_len, 1'b1, page_end));
            run_code = CODE_CLEAR;
            run_len = 0;
            col_count = 0;
            row_count = page_end ? '0 : row_count + 1'b1;
        end else begin
            col_count++;
        end
    endtask

    // driver: bursts of random length separated by random gaps
    int     burst_left;
    int     gap_left;
    t_pixel on_wire;

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                encode_pixel(on_wire);
                pixels_taken++;
            end
            // hold the word while the block stalls
            if (!(pix_ch.valid && !pix_ch.ready)) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_queue.size() > 0) begin
                    on_wire = pixel_queue.pop_front();
                    pix_ch.fg_red   <= on_wire.fg_red;
                    pix_ch.fg_green <= on_wire.fg_green;
                    pix_ch.fg_blue  <= on_wire.fg_blue;
                    pix_ch.bg_red   <= on_wire.bg_red;
                    pix_ch.bg_green <= on_wire.bg_green;
                    pix_ch.bg_blue  <= on_wire.bg_blue;
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 9) == 0) begin
                        burst_left = $urandom_range(60, 200);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                               : $urandom_range(0, 4);
                    end
                end
                pix_ch.valid <= next_valid;
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h want %0h",
                                      runs_checked, what, got, want));
    endtask

    // monitor: compare each accepted run word, stall on a rotating pattern
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    next_ready;
        if (!i_rst_n) begin
            run_ch.ready <= 1'b0;
            cycle_count = 0;
        end else begin
            cycle_count++;
            if (run_ch.valid && run_ch.ready) begin
                got.run_word     = run_ch.run_word;
                got.last_of_row  = run_ch.last_of_row;
                got.last_of_page = run_ch.last_of_page;
                got.fg_nonblack  = run_ch.fg_nonblack;
                got.bg_differs   = run_ch.bg_differs;
                got.ref_red      = run_ch.ref_red;
                got.ref_green    = run_ch.ref_green;
                got.ref_blue     = run_ch.ref_blue;
                if (runs_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected run word %0h", got.run_word));
                end else begin
                    want = runs_due.pop_front();
                    check_field("run_word", got.run_word, want.run_word);
                    check_field("last_of_row", 32'(got.last_of_row),
                                32'(want.last_of_row));
                    check_field("last_of_page", 32'(got.last_of_page),
                                32'(want.last_of_page));
                    check_field("fg_nonblack", 32'(got.fg_nonblack),
                                32'(want.fg_nonblack));
                    check_field("bg_differs", 32'(got.bg_differs),
                                32'(want.bg_differs));
                    check_field("ref_red", 32'(got.ref_red), 32'(want.ref_red));
                    check_field("ref_green", 32'(got.ref_green), 32'(want.ref_green));
                    check_field("ref_blue", 32'(got.ref_blue), 32'(want.ref_blue));
                    if (want.last_of_row)
                        rows_closed++;
                    if (want.last_of_page)
                        pages_closed++;
                end
                runs_checked++;
            end
            case ((cycle_count >> 7) % 4)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (cycle_count % 4) == 0;
                default: next_ready = (cycle_count % 13) >= 10;
            endcase
            run_ch.ready <= next_ready;
        end
    end

    function automatic t_pixel px(input int fr, input int fg, input int fb,
                                  input int br, input int bgc, input int bb);
        t_pixel p;
        p = {8'(fr), 8'(fg), 8'(fb), 8'(br), 8'(bgc), 8'(bb)};
        return p;
    endfunction

    // channel values, biased toward the edges of the six palette levels
    function automatic logic [7:0] random_channel();
        logic [7:0] edges[14];
        edges = '{8'd0, 8'd41, 8'd42, 8'd84, 8'd85, 8'd127, 8'd128,
                  8'd170, 8'd171, 8'd212, 8'd213, 8'd214, 8'd254, 8'd255};
        if ($urandom_range(0, 9) < 4)
            return edges[$urandom_range(0, 13)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel      p;
        int          pick;
        logic [23:0] bg;
        pick = $urandom_range(0, 99);
        p = last_pixel;
        if ($urandom_range(0, 19) == 0)
            page_bg = {random_channel(), random_channel(), random_channel()};
        bg = ($urandom_range(0, 9) < 7) ? page_bg
                                        : {random_channel(), random_channel(), random_channel()};
        if (pick < 35) begin
            // repeat: extend the current run
        end else if (pick < 50) begin
            p = {bg, bg};
        end else if (pick < 58) begin
            p = {24'h0, bg};
        end else if (pick < 66) begin
            p.fg_green = p.fg_green ^ 8'h01;
            p.bg_red = bg[23:16];
            p.bg_green = bg[15:8];
            p.bg_blue = bg[7:0];
        end else begin
            p = {random_channel(), random_channel(), random_channel(), bg};
        end
        last_pixel = p;
        return p;
    endfunction

    // block drains: all pixels taken, all words seen, then an idle wait
    task automatic wait_drained();
        while (pixels_taken != pixels_queued || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_size(input int w, input int h);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IMAGE_WIDTH;
        cfg_data <= CFG_DATA_BITS'(w);
        width_reg = COUNT_BITS'(w);
        @(posedge i_clk);
        cfg_idx  <= CFG_IMAGE_HEIGHT;
        cfg_data <= CFG_DATA_BITS'(h);
        height_reg = COUNT_BITS'(h);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        size_settings++;
    endtask

    task automatic queue_pixel(input t_pixel p);
        pixel_queue.push_back(p);
        pixels_queued++;
    endtask

    int phase_w[10] = '{0, 1, 7, 16, 65535, 3, 33, 2, 12, 65535};
    int phase_h[10] = '{0, 3, 3, 4, 65535, 0, 2, 65535, 5, 1};
    int phase_n[10] = '{40, 60, 200, 300, 150, 100, 300, 150, 100, 50};

    initial begin
        width_reg = 1;
        height_reg = 1;
        col_count = 0;
        row_count = 0;
        run_code = CODE_CLEAR;
        run_len = 0;
        ref_colour = 0;
        fg_seen = 1'b0;
        bg_varies = 1'b0;
        last_pixel = '0;
        page_bg = 24'hffffff;
        @(posedge i_rst_n);
        repeat (2) @(posedge i_clk);

        // directed: two 5x2 pages with level edges, black and transparent pixels
        set_size(5, 2);
        queue_pixel(px(0, 0, 0, 255, 255, 255));
        queue_pixel(px(41, 41, 41, 255, 255, 255));
        queue_pixel(px(42, 42, 42, 255, 255, 255));
        queue_pixel(px(255, 255, 255, 255, 255, 255));
        queue_pixel(px(254, 213, 212, 0, 0, 0));
        queue_pixel(px(214, 0, 255, 1, 2, 3));
        queue_pixel(px(214, 0, 255, 1, 2, 3));
        queue_pixel(px(1, 2, 3, 1, 2, 3));
        queue_pixel(px(1, 2, 3, 1, 2, 3));
        queue_pixel(px(128, 64, 32, 255, 255, 255));
        queue_pixel(px(7, 7, 7, 7, 7, 7));
        queue_pixel(px(255, 0, 0, 7, 7, 7));
        queue_pixel(px(0, 255, 0, 7, 7, 7));
        queue_pixel(px(0, 0, 255, 7, 7, 7));
        queue_pixel(px(0, 0, 0, 7, 7, 7));
        repeat (5) queue_pixel(px(85, 170, 255, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            set_size(phase_w[ph], phase_h[ph]);
            for (int k = 0; k < phase_n[ph]; k++)
                queue_pixel(random_pixel());
            wait_drained();
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d pixels over %0d size settings, zero and full-range included.",
                 pixels_taken, size_settings);
        $display("Checked %0d run words: %0d row ends, %0d page ends.",
                 runs_checked, rows_closed, pages_closed);
        if (error_count == 0 && runs_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
